// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file sdes_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, skipped while reset is high
`define SDES_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define SDES_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/sdes_pkg.sv =====
// types and constants for the stream difference error statistics block
// no dependencies
`default_nettype none

package sdes_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int ERR_W      = SAMPLE_W + 1;
   localparam int ABS_W      = SAMPLE_W;
   localparam int SQE_W      = 2 * ABS_W;
   localparam int SQO_W      = 2 * SAMPLE_W - 1;
   localparam int SUM_ABS_W  = 40;
   localparam int SUM_SQE_W  = 56;
   localparam int SUM_SQO_W  = 55;
   localparam int IDX_W      = 24;
   localparam int CNT_W      = 25;
   localparam int TDATA_W    = 312;
   localparam int REQ_DATA_W = 2 * SAMPLE_W;

   localparam logic [CNT_W-1:0] MAX_RUN_LENGTH = CNT_W'(16777216);

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [ERR_W-1:0]    err_type;

   localparam err_type    ERR_INIT_MIN  = {1'b0, {(ERR_W-1){1'b1}}};
   localparam err_type    ERR_INIT_MAX  = {1'b1, {(ERR_W-1){1'b0}}};
   localparam sample_type ORIG_INIT_MIN = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam sample_type ORIG_INIT_MAX = {1'b1, {(SAMPLE_W-1){1'b0}}};

   // product stage contents handed from front end to accumulators
   typedef struct packed {
      logic               valid;
      logic               last;
      err_type            err;
      logic [ABS_W-1:0]   abs_err;
      sample_type         orig;
      logic [SQE_W-1:0]   sq_err;
      logic [SQO_W-1:0]   sq_orig;
   } prod_type;

   // result fields, packed lowest field last
   typedef struct packed {
      logic [TDATA_W-307-1:0] pad;
      logic [CNT_W-1:0]       sample_count;
      sample_type             largest_original;
      sample_type             min_original;
      logic [IDX_W-1:0]       largest_error_index;
      logic [IDX_W-1:0]       min_error_index;
      err_type                largest_error;
      err_type                min_error;
      logic [SUM_SQO_W-1:0]   sum_sq_original;
      logic [SUM_SQE_W-1:0]   sum_sq_error;
      logic [SUM_ABS_W-1:0]   sum_abs_error;
      err_type                error_sample;
   } rsp_data_type;

endpackage

`default_nettype wire

// ===== hw/rtl/sdes_front.sv =====
// input register, difference, magnitudes and squares into the product register
// depends on sdes_pkg
`default_nettype none

module sdes_front
   import sdes_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // original_sample, decoded_sample
   input  wire logic                  req_tlast,   // last_of_run
   output prod_type                   prod,
   input  wire logic                  prod_ready
);

   logic       in_valid_ff, in_valid_in;
   logic       in_last_ff;
   sample_type in_orig_ff, in_dec_ff;
   prod_type   prod_ff, prod_in;

   logic       prod_adv;
   logic       in_adv;
   err_type    err, err_neg, orig_ext, orig_neg;
   logic [ABS_W-1:0] abs_err, abs_orig;
   logic [SQE_W-1:0] sq_err;
   logic [SQE_W-1:0] sq_orig_full;

   assign prod_adv   = !prod_ff.valid || prod_ready;
   assign in_adv     = !in_valid_ff || prod_adv;
   assign req_tready = in_adv;
   assign in_valid_in = in_adv ? req_tvalid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_adv && req_tvalid) begin
         in_orig_ff <= sample_type'(req_tdata[SAMPLE_W-1:0]);
         in_dec_ff  <= sample_type'(req_tdata[REQ_DATA_W-1:SAMPLE_W]);
         in_last_ff <= req_tlast;
      end
   end

   always_comb begin
      err          = err_type'(in_orig_ff) - err_type'(in_dec_ff);
      err_neg      = -err;
      abs_err      = err[ERR_W-1] ? err_neg[ABS_W-1:0] : err[ABS_W-1:0];
      orig_ext     = err_type'(in_orig_ff);
      orig_neg     = -orig_ext;
      abs_orig     = in_orig_ff[SAMPLE_W-1] ? orig_neg[ABS_W-1:0] : orig_ext[ABS_W-1:0];
      sq_err       = SQE_W'(abs_err) * SQE_W'(abs_err);
      sq_orig_full = SQE_W'(abs_orig) * SQE_W'(abs_orig);
   end

   always_comb begin
      prod_in         = prod_ff;
      prod_in.valid   = prod_adv ? in_valid_ff : prod_ff.valid;
      if (prod_adv && in_valid_ff) begin
         prod_in.last    = in_last_ff;
         prod_in.err     = err;
         prod_in.abs_err = abs_err;
         prod_in.orig    = in_orig_ff;
         prod_in.sq_err  = sq_err;
         prod_in.sq_orig = sq_orig_full[SQO_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ff <= '0;
      end else begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/sdes_accum.sv =====
// run accumulators, extreme trackers and the result register
// depends on sdes_pkg
`default_nettype none

module sdes_accum
   import sdes_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire prod_type           prod,
   output logic                    prod_ready,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [TDATA_W-1:0]      rsp_tdata,   // error_sample, sum_abs_error, sum_sq_error,
                                                // sum_sq_original, min_error, largest_error,
                                                // min_error_index, largest_error_index,
                                                // min_original, largest_original,
                                                // sample_count
   output logic                    rsp_tuser    // totals_valid
);

   logic [SUM_ABS_W-1:0] acc_abs_ff, acc_abs_in;
   logic [SUM_SQE_W-1:0] acc_sqe_ff, acc_sqe_in;
   logic [SUM_SQO_W-1:0] acc_sqo_ff, acc_sqo_in;
   err_type              min_err_ff, min_err_in, max_err_ff, max_err_in;
   logic [IDX_W-1:0]     min_pos_ff, min_pos_in, max_pos_ff, max_pos_in;
   sample_type           min_orig_ff, min_orig_in, max_orig_ff, max_orig_in;
   logic [CNT_W-1:0]     pos_ff, pos_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_user_ff, rsp_user_in;
   rsp_data_type         rsp_data_ff, rsp_data_in;

   logic                 fire;
   logic [SUM_ABS_W:0]   sum_abs;
   logic [SUM_SQE_W:0]   sum_sqe;
   logic [SUM_SQO_W:0]   sum_sqo;
   logic [SUM_ABS_W-1:0] upd_abs;
   logic [SUM_SQE_W-1:0] upd_sqe;
   logic [SUM_SQO_W-1:0] upd_sqo;
   err_type              upd_min_err, upd_max_err;
   logic [IDX_W-1:0]     upd_min_pos, upd_max_pos, idx;
   sample_type           upd_min_orig, upd_max_orig;
   logic [CNT_W-1:0]     upd_pos;
   logic                 below_max;

   assign prod_ready = !rsp_valid_ff || rsp_tready;
   assign fire       = prod.valid && prod_ready;

   always_comb begin
      below_max = pos_ff < MAX_RUN_LENGTH;
      idx       = below_max ? pos_ff[IDX_W-1:0] : IDX_W'(MAX_RUN_LENGTH - CNT_W'(1));
      upd_pos   = below_max ? pos_ff + CNT_W'(1) : pos_ff;

      sum_abs = {1'b0, acc_abs_ff} + (SUM_ABS_W+1)'(prod.abs_err);
      sum_sqe = {1'b0, acc_sqe_ff} + (SUM_SQE_W+1)'(prod.sq_err);
      sum_sqo = {1'b0, acc_sqo_ff} + (SUM_SQO_W+1)'(prod.sq_orig);
      upd_abs = sum_abs[SUM_ABS_W] ? {SUM_ABS_W{1'b1}} : sum_abs[SUM_ABS_W-1:0];
      upd_sqe = sum_sqe[SUM_SQE_W] ? {SUM_SQE_W{1'b1}} : sum_sqe[SUM_SQE_W-1:0];
      upd_sqo = sum_sqo[SUM_SQO_W] ? {SUM_SQO_W{1'b1}} : sum_sqo[SUM_SQO_W-1:0];

      upd_min_err = min_err_ff;
      upd_min_pos = min_pos_ff;
      if (prod.err < min_err_ff) begin
         upd_min_err = prod.err;
         upd_min_pos = idx;
      end
      upd_max_err = max_err_ff;
      upd_max_pos = max_pos_ff;
      if (prod.err > max_err_ff) begin
         upd_max_err = prod.err;
         upd_max_pos = idx;
      end
      upd_min_orig = (prod.orig < min_orig_ff) ? prod.orig : min_orig_ff;
      upd_max_orig = (prod.orig > max_orig_ff) ? prod.orig : max_orig_ff;
   end

   always_comb begin
      acc_abs_in  = acc_abs_ff;
      acc_sqe_in  = acc_sqe_ff;
      acc_sqo_in  = acc_sqo_ff;
      min_err_in  = min_err_ff;
      max_err_in  = max_err_ff;
      min_pos_in  = min_pos_ff;
      max_pos_in  = max_pos_ff;
      min_orig_in = min_orig_ff;
      max_orig_in = max_orig_ff;
      pos_in      = pos_ff;
      if (fire) begin
         if (prod.last) begin
            acc_abs_in  = '0;
            acc_sqe_in  = '0;
            acc_sqo_in  = '0;
            min_err_in  = ERR_INIT_MIN;
            max_err_in  = ERR_INIT_MAX;
            min_pos_in  = '0;
            max_pos_in  = '0;
            min_orig_in = ORIG_INIT_MIN;
            max_orig_in = ORIG_INIT_MAX;
            pos_in      = '0;
         end else begin
            acc_abs_in  = upd_abs;
            acc_sqe_in  = upd_sqe;
            acc_sqo_in  = upd_sqo;
            min_err_in  = upd_min_err;
            max_err_in  = upd_max_err;
            min_pos_in  = upd_min_pos;
            max_pos_in  = upd_max_pos;
            min_orig_in = upd_min_orig;
            max_orig_in = upd_max_orig;
            pos_in      = upd_pos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_abs_ff  <= '0;
         acc_sqe_ff  <= '0;
         acc_sqo_ff  <= '0;
         min_err_ff  <= ERR_INIT_MIN;
         max_err_ff  <= ERR_INIT_MAX;
         min_pos_ff  <= '0;
         max_pos_ff  <= '0;
         min_orig_ff <= ORIG_INIT_MIN;
         max_orig_ff <= ORIG_INIT_MAX;
         pos_ff      <= '0;
      end else begin
         acc_abs_ff  <= acc_abs_in;
         acc_sqe_ff  <= acc_sqe_in;
         acc_sqo_ff  <= acc_sqo_in;
         min_err_ff  <= min_err_in;
         max_err_ff  <= max_err_in;
         min_pos_ff  <= min_pos_in;
         max_pos_ff  <= max_pos_in;
         min_orig_ff <= min_orig_in;
         max_orig_ff <= max_orig_in;
         pos_ff      <= pos_in;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = prod_ready ? prod.valid : rsp_valid_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_data_in  = rsp_data_ff;
      if (fire) begin
         rsp_user_in              = prod.last;
         rsp_data_in              = '0;
         rsp_data_in.error_sample = prod.err;
         if (prod.last) begin
            rsp_data_in.sum_abs_error       = upd_abs;
            rsp_data_in.sum_sq_error        = upd_sqe;
            rsp_data_in.sum_sq_original     = upd_sqo;
            rsp_data_in.min_error           = upd_min_err;
            rsp_data_in.largest_error       = upd_max_err;
            rsp_data_in.min_error_index     = upd_min_pos;
            rsp_data_in.largest_error_index = upd_max_pos;
            rsp_data_in.min_original        = upd_min_orig;
            rsp_data_in.largest_original    = upd_max_orig;
            rsp_data_in.sample_count        = upd_pos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_user_ff <= rsp_user_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/stream_difference_error_stats.sv =====
// a result passes the input, product and result registers on its way to rsp
// throughput: one transfer per cycle on each side while rsp_tready does not stall, set by the accumulator loop
// a stalled rsp side holds up to three items inside before req_tready drops
// reset: synchronous, clears all valid flags and returns every run total to its start value
// top level, depends on sdes_pkg, sdes_front and sdes_accum
`default_nettype none

module stream_difference_error_stats
   import sdes_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // original_sample, decoded_sample
   input  wire logic                  req_tlast,   // last_of_run
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [TDATA_W-1:0]         rsp_tdata,   // error_sample, sum_abs_error, sum_sq_error,
                                                   // sum_sq_original, min_error, largest_error,
                                                   // min_error_index, largest_error_index,
                                                   // min_original, largest_original,
                                                   // sample_count
   output logic                       rsp_tuser    // totals_valid
);

   prod_type prod;
   logic     prod_ready;

   sdes_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .prod       (prod),
      .prod_ready (prod_ready)
   );

   sdes_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .prod       (prod),
      .prod_ready (prod_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/sdes_checker.sv =====
// port-level checks for stream_difference_error_stats, bound to the top level
// depends on sdes_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module sdes_checker
   import sdes_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [TDATA_W-1:0]    rsp_tdata,
   input wire logic                  rsp_tuser
);

   logic       rsp_stall;
   logic       plain;
   logic       totals;
   logic [TDATA_W-ERR_W-1:0] upper;
   logic [CNT_W-1:0] count;
   sample_type omin, omax;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign plain     = rsp_tvalid && !rsp_tuser;
   assign totals    = rsp_tvalid && rsp_tuser;
   assign upper     = rsp_tdata[TDATA_W-1:ERR_W];
   assign count     = rsp_tdata[306:282];
   assign omin      = sample_type'(rsp_tdata[265:250]);
   assign omax      = sample_type'(rsp_tdata[281:266]);

   `SDES_ASSERT(a_hold, clock, reset, rsp_stall |=> rsp_tvalid && $stable(rsp_tdata), "rsp moved")
   `SDES_ASSERT(a_plain_zero, clock, reset, plain |-> upper == '0, "totals on a plain transfer")
   `SDES_ASSERT(a_count_nonzero, clock, reset, totals |-> count != '0, "zero sample count")
   `SDES_ASSERT(a_orig_order, clock, reset, totals |-> omin <= omax, "min original above max")
   `SDES_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid, "rsp valid after reset")

endmodule

bind stream_difference_error_stats sdes_checker u_sdes_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
